FILE: rtl/core/tmf_pkg.sv
// Shared constants for the trimmed mean filter.
package tmf_pkg;

  // Default sizing of the sample store and sample width.
  localparam int DEF_MAX_SAMPLES = 32;
  localparam int DEF_SAMPLE_BITS = 16;

  // Configuration register widths and reset values.
  localparam int SAMPLE_COUNT_W   = 6;
  localparam int TRIM_COUNT_W     = 4;
  localparam int CFG_DATA_W       = 6;
  localparam int CFG_IDX_W        = 1;
  localparam logic [SAMPLE_COUNT_W-1:0] SAMPLE_COUNT_RST = 6'd10;
  localparam logic [TRIM_COUNT_W-1:0]   TRIM_COUNT_RST   = 4'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_COUNT   = 1'd1;

endpackage

FILE: rtl/core/trimmed_mean_filter.sv
// Trimmed mean filter: batch gather, rank-select over a sample memory, iterative divide.
//
//   channel | ports                            | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_ready, in_sample    | input word
//   out     | out_valid, out_ready, out_mean,  | result word
//           | out_bad_setting                  |
//   cfg     | cfg_valid, cfg_ready, cfg_index, | register write
//           | cfg_data                         |
//
// Sample words are taken only while the block is idle. The word that completes a batch
// of n samples starts a computation whose length is set by the single read port of the
// sample memory, which is swept once per sample to find its rank, and by the
// one-bit-per-cycle divider; a kept sum of zero skips the divider's load step.
// A batch with too much trimming skips the computation and goes straight to its report.
// Reset clears the batch fill level and the result valid flag and restores the register
// reset values; the memory keeps its contents. Intake stops until a result is reported.
module trimmed_mean_filter #(
  parameter int MAX_SAMPLES = tmf_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = tmf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Sample input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  // Result output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_mean,
  output logic                                out_bad_setting,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tmf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tmf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tmf_pkg::*;

  localparam int AW     = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int EXT_W  = (CNT_W > SAMPLE_COUNT_W) ? CNT_W : SAMPLE_COUNT_W;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RDI  = 7'b0000010,
    S_LATI = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_ACC  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [SAMPLE_COUNT_W-1:0]   sample_count_r, sample_count_nxt;
  logic [TRIM_COUNT_W-1:0]     trim_count_r, trim_count_nxt;
  logic [AW-1:0]               fill_r, fill_nxt;
  logic [AW-1:0]               i_r, i_nxt;
  logic [CNT_W-1:0]            j_r, j_nxt;
  logic [CNT_W-1:0]            rank_r, rank_nxt;
  logic                        cmp_v_r, cmp_v_nxt;
  logic [AW-1:0]               cmp_j_r, cmp_j_nxt;
  logic signed [SAMPLE_BITS-1:0] pivot_r, pivot_nxt;
  logic signed [SUM_W-1:0]     sum_r, sum_nxt;
  logic                        neg_r, neg_nxt;
  logic [SUM_W-1:0]            quo_r, quo_nxt;
  logic [CNT_W-1:0]            rem_r, rem_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic                        bad_r, bad_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_mean_r, out_mean_nxt;
  logic                        out_bad_r, out_bad_nxt;

  // Sample memory with registered read data.
  logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] rdata_r;
  logic [AW-1:0]                 rd_addr;

  logic              in_fire;
  logic [EXT_W-1:0]  sc_ext, n_ext, twice_t, trim_ext, hi_lim, rank_ext;
  logic [CNT_W-1:0]  n_eff, keep, fill_inc, i_inc;
  logic              bad_now, cmp_less, rank_kept;
  logic [CNT_W:0]    div_sh, div_diff;
  logic              div_bit;
  logic [SUM_W-1:0]  q_signed;

  assign in_ready        = (state_r == S_IDLE);
  assign in_fire         = in_valid && in_ready;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_mean        = out_mean_r;
  assign out_bad_setting = out_bad_r;

  // Effective batch size, trim limits and the keep count.
  always_comb begin
    sc_ext   = EXT_W'(sample_count_r);
    if (sc_ext == '0) begin
      n_ext = EXT_W'(1);
    end else if (sc_ext > EXT_W'(MAX_SAMPLES)) begin
      n_ext = EXT_W'(MAX_SAMPLES);
    end else begin
      n_ext = sc_ext;
    end
    n_eff    = n_ext[CNT_W-1:0];
    trim_ext = EXT_W'(trim_count_r);
    twice_t  = EXT_W'({trim_count_r, 1'b0});
    bad_now  = (twice_t >= n_ext);
    keep     = CNT_W'(n_ext - twice_t);
    hi_lim   = n_ext - trim_ext;
    rank_ext = EXT_W'(rank_r);
    rank_kept = (rank_ext >= trim_ext) && (rank_ext < hi_lim);
    fill_inc = CNT_W'(fill_r) + CNT_W'(1);
    i_inc    = CNT_W'(i_r) + CNT_W'(1);
  end

  // Rank compare: earlier index wins a tie so every sorted position maps to one sample.
  assign cmp_less = (rdata_r < pivot_r) || ((rdata_r == pivot_r) && (cmp_j_r < i_r));

  // One restoring divide step on the magnitude of the sum.
  always_comb begin
    div_sh   = {rem_r, quo_r[SUM_W-1]};
    div_diff = div_sh - {1'b0, keep};
    div_bit  = (div_sh >= {1'b0, keep});
  end

  assign q_signed = neg_r ? (~quo_r + SUM_W'(1)) : quo_r;
  assign rd_addr  = (state_r == S_RDI) ? i_r : j_r[AW-1:0];

  // Memory write on sample intake, read every cycle.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem[fill_r] <= in_sample;
    end
    rdata_r <= mem[rd_addr];
  end

  // Sequencer: gather, rank every sample, accumulate kept ones, divide, report; too much trimming skips to report.
  always_comb begin
    state_nxt        = state_r;
    sample_count_nxt = sample_count_r;
    trim_count_nxt   = trim_count_r;
    fill_nxt         = fill_r;
    i_nxt            = i_r;
    j_nxt            = j_r;
    rank_nxt         = rank_r;
    cmp_v_nxt        = 1'b0;
    cmp_j_nxt        = j_r[AW-1:0];
    pivot_nxt        = pivot_r;
    sum_nxt          = sum_r;
    neg_nxt          = neg_r;
    quo_nxt          = quo_r;
    rem_nxt          = rem_r;
    step_nxt         = step_r;
    bad_nxt          = bad_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_mean_nxt     = out_mean_r;
    out_bad_nxt      = out_bad_r;

    if (cfg_valid) begin
      case (cfg_index)
        REG_SAMPLE_COUNT: sample_count_nxt = cfg_data[SAMPLE_COUNT_W-1:0];
        REG_TRIM_COUNT:   trim_count_nxt   = cfg_data[TRIM_COUNT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (fill_inc >= n_eff) begin
            fill_nxt = '0;
            bad_nxt  = bad_now;
            i_nxt    = '0;
            sum_nxt  = '0;
            state_nxt = bad_now ? S_OUT : S_RDI;
          end else begin
            fill_nxt = fill_inc[AW-1:0];
          end
        end
      end
      S_RDI: begin
        state_nxt = S_LATI;
      end
      S_LATI: begin
        pivot_nxt = rdata_r;
        j_nxt     = '0;
        rank_nxt  = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (cmp_v_r && cmp_less) begin
          rank_nxt = rank_r + CNT_W'(1);
        end
        if (j_r != n_eff) begin
          cmp_v_nxt = 1'b1;
          j_nxt     = j_r + CNT_W'(1);
        end else begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (rank_kept) begin
          sum_nxt = sum_r + SUM_W'(pivot_r);
        end
        if (i_inc == n_eff) begin
          state_nxt = S_DIV;
        end else begin
          i_nxt     = i_inc[AW-1:0];
          state_nxt = S_RDI;
        end
        // Divider set-up; overwritten each pass, final on the last one.
        neg_nxt  = 1'b0;
        rem_nxt  = '0;
        step_nxt = '0;
      end
      S_DIV: begin
        if (step_r == '0 && rem_r == '0 && !neg_r && quo_r == '0 && sum_r != '0) begin
          // First step: load the magnitude of the sum.
          neg_nxt = sum_r[SUM_W-1];
          quo_nxt = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
        end else begin
          rem_nxt  = div_bit ? div_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
          quo_nxt  = {quo_r[SUM_W-2:0], div_bit};
          step_nxt = step_r + STEP_W'(1);
          if (step_r == STEP_W'(SUM_W - 1)) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_bad_nxt   = bad_r;
          out_mean_nxt  = bad_r ? '0 : q_signed[SAMPLE_BITS-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers take reset; datapath registers do not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      sample_count_r <= SAMPLE_COUNT_RST;
      trim_count_r   <= TRIM_COUNT_RST;
      fill_r         <= '0;
      cmp_v_r        <= 1'b0;
      out_valid_r    <= 1'b0;
      quo_r          <= '0;
      neg_r          <= 1'b0;
      rem_r          <= '0;
      step_r         <= '0;
    end else begin
      state_r        <= state_nxt;
      sample_count_r <= sample_count_nxt;
      trim_count_r   <= trim_count_nxt;
      fill_r         <= fill_nxt;
      cmp_v_r        <= cmp_v_nxt;
      out_valid_r    <= out_valid_nxt;
      quo_r          <= (state_r == S_ACC) ? '0 : quo_nxt;
      neg_r          <= neg_nxt;
      rem_r          <= rem_nxt;
      step_r         <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    rank_r     <= rank_nxt;
    cmp_j_r    <= cmp_j_nxt;
    pivot_r    <= pivot_nxt;
    sum_r      <= sum_nxt;
    bad_r      <= bad_nxt;
    out_mean_r <= out_mean_nxt;
    out_bad_r  <= out_bad_nxt;
  end

`ifndef SYNTHESIS
  // A completing sample always restarts the batch.
  a_batch_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (fill_inc >= n_eff)) |=> (fill_r == '0))
    else $error("fill level not cleared at batch end");

  // A flagged result always carries a zero mean.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_mean_r == '0))
    else $error("bad setting result with non-zero mean");

  // A rank never reaches the batch size.
  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> (rank_r < n_eff))
    else $error("rank out of range");

  // The scan index never runs past the batch.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (j_r <= n_eff))
    else $error("scan index past batch size");
`endif

endmodule

FILE: tb/trimmed_mean_filter_test.sv
// Self-checking testbench for the trimmed mean filter: directed table, then random batches.
module trimmed_mean_filter_test;
  import tmf_pkg::*;

  typedef logic signed [DEF_SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t mean;
    logic    bad;
  } result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    index;
    logic [CFG_DATA_W-1:0]   data;
    sample_t                 value;
    logic                    typed;
    sample_t                 mean;
    logic                    bad;
  } row_t;

  localparam sample_t MAX_POS = 16'sh7fff;
  localparam sample_t MAX_NEG = 16'sh8000;
  localparam int STORE_DEPTH   = DEF_MAX_SAMPLES;
  localparam int RANDOM_WORDS  = 1025;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 1200;
  localparam int QUIET_LIMIT   = 20000;
  localparam int PAD_W         = CFG_DATA_W - TRIM_COUNT_W;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  sample_t               in_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sample_t               out_mean;
  logic                  out_bad_setting;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SAMPLE_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: its own copy of the registers and the batch being gathered.
  logic [SAMPLE_COUNT_W-1:0] batch_reg = SAMPLE_COUNT_RST;
  logic [TRIM_COUNT_W-1:0]   trim_reg = TRIM_COUNT_RST;
  sample_t                   batch_words [STORE_DEPTH];
  int                        fill = 0;

  result_t pending_means [$];
  row_t    directed [$];
  result_t head;
  int      fault_count = 0;
  int      quiet = 0;
  bit      steady = 1'b0;

  trimmed_mean_filter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_mean        (out_mean),
    .out_bad_setting (out_bad_setting),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Batch size in force: zero acts as one and large values saturate.
  function automatic int batch_size(input logic [SAMPLE_COUNT_W-1:0] count);
    if (count == 0) return 1;
    if (count > STORE_DEPTH) return STORE_DEPTH;
    return count;
  endfunction

  // Adds one word to the batch; when the batch is full, works out its trimmed mean or flags too much trimming.
  function automatic bit gather_sample(input sample_t v, output sample_t avg, output logic flag);
    int      n;
    int      cut;
    int      keep;
    int      j;
    longint  total;
    sample_t x;
    sample_t ordered [STORE_DEPTH];
    n = batch_size(batch_reg);
    cut = trim_reg;
    avg = '0;
    flag = 1'b0;
    if (fill < STORE_DEPTH) batch_words[fill] = v;
    fill++;
    if (fill < n) return 1'b0;
    fill = 0;
    if (2 * cut >= n) begin
      flag = 1'b1;
      return 1'b1;
    end
    // Insertion sort of the first n words, ascending.
    ordered = batch_words;
    for (int i = 1; i < n; i++) begin
      x = ordered[i];
      j = i;
      while (j > 0 && x < ordered[j-1]) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = x;
    end
    total = 0;
    for (int i = cut; i < n - cut; i++) total += ordered[i];
    keep = n - 2 * cut;
    avg = sample_t'(total / keep);
    return 1'b1;
  endfunction

  function automatic row_t smp(input sample_t v);
    return '{ROW_SAMPLE, REG_SAMPLE_COUNT, '0, v, 1'b0, '0, 1'b0};
  endfunction

  function automatic row_t smp_chk(input sample_t v, input sample_t m, input logic b);
    return '{ROW_SAMPLE, REG_SAMPLE_COUNT, '0, v, 1'b1, m, b};
  endfunction

  function automatic row_t wr(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    return '{ROW_WRITE, idx, d, '0, 1'b0, '0, 1'b0};
  endfunction

  // A mix of full-range words, extremes and narrow spreads that give ties.
  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return sample_t'($urandom);
    if (r < 45) begin
      case ($urandom_range(0, 4))
        0: return MAX_NEG;
        1: return MAX_POS;
        2: return 16'sd0;
        3: return -16'sd1;
        default: return 16'sd1;
      endcase
    end
    if (r < 75) return sample_t'(int'($urandom_range(0, 16)) - 8);
    return sample_t'(int'($urandom_range(0, 2000)) - 1000);
  endfunction

  // Offers one sample word, with random gaps, and records what it should produce.
  task automatic push_sample(input sample_t v, input logic typed, input sample_t m,
                             input logic b);
    result_t r;
    bit      done;
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    done = gather_sample(v, r.mean, r.bad);
    if (done) begin
      if (typed) begin
        r.mean = m;
        r.bad = b;
      end
      pending_means.push_back(r);
    end
  endtask

  // Writes one register and mirrors it in the predictor.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SAMPLE_COUNT) batch_reg = d;
    else trim_reg = d[TRIM_COUNT_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Holds the sender back until every expected result word has come and the block is quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result checking against the oldest expectation, and random back-pressure.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_means.size() == 0) begin
        fault_count++;
        $display("%0t: result word with nothing expected: mean %0d, bad_setting %0b",
                 $time, out_mean, out_bad_setting);
      end else begin
        head = pending_means.pop_front();
        if (out_mean !== head.mean) begin
          fault_count++;
          $display("%0t: mean expected %0d, actual %0d", $time, head.mean, out_mean);
        end
        if (out_bad_setting !== head.bad) begin
          fault_count++;
          $display("%0t: bad_setting expected %0b, actual %0b", $time, head.bad,
                   out_bad_setting);
        end
      end
    end
    out_ready <= steady || ($urandom_range(0, 99) >= 16);
  end

  // Watchdog on cycles without any word moving on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("trimmed_mean_filter: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int                        sent;
    int                        phase;
    int                        n;
    int                        len;
    logic [SAMPLE_COUNT_W-1:0] count;
    logic [TRIM_COUNT_W-1:0]   trim;
    logic [SAMPLE_COUNT_W-1:0] forced_count [4];
    logic [TRIM_COUNT_W-1:0]   forced_trim [4];
    forced_count = '{6'd63, 6'd32, 6'd0, 6'd31};
    forced_trim  = '{4'd15, 4'd0, 4'd15, 4'd15};

    directed = '{
      // Reset setting: batches of ten, two trimmed from each end.
      smp(MAX_POS), smp(MAX_POS), smp(MAX_POS), smp(MAX_POS), smp(MAX_POS),
      smp(MAX_POS), smp(MAX_POS), smp(MAX_POS), smp(MAX_POS),
      smp_chk(MAX_POS, MAX_POS, 1'b0),
      // A batch size of zero acts as one.
      wr(REG_SAMPLE_COUNT, 6'd0), wr(REG_TRIM_COUNT, 6'd0),
      smp_chk(MAX_NEG, MAX_NEG, 1'b0),
      // Too much trimming on a single word.
      wr(REG_TRIM_COUNT, 6'd1),
      smp_chk(16'sd5, 16'sd0, 1'b1),
      // Median of three with both extremes present.
      wr(REG_SAMPLE_COUNT, 6'd3),
      smp(MAX_POS), smp(MAX_NEG), smp_chk(16'sd7, 16'sd7, 1'b0),
      // Batch size lowered mid-batch; the negative mean truncates towards zero.
      wr(REG_SAMPLE_COUNT, 6'd5), wr(REG_TRIM_COUNT, 6'd0),
      smp(-16'sd1), smp(-16'sd2), smp(-16'sd2),
      wr(REG_SAMPLE_COUNT, 6'd2),
      smp_chk(16'sd4, -16'sd1, 1'b0),
      // Extremes trimmed away, positive mean truncated.
      wr(REG_SAMPLE_COUNT, 6'd4), wr(REG_TRIM_COUNT, 6'd1),
      smp(16'sd3), smp(MAX_NEG), smp(16'sd4), smp_chk(MAX_POS, 16'sd3, 1'b0),
      // Trimming that exactly consumes the batch.
      wr(REG_SAMPLE_COUNT, 6'd2),
      smp(16'sd100), smp_chk(-16'sd100, 16'sd0, 1'b1)
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(directed[i].index, directed[i].data);
      end else begin
        push_sample(directed[i].value, directed[i].typed, directed[i].mean, directed[i].bad);
      end
    end

    // Random phases: a new setting while idle, then a run of words.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      wait_idle();
      if (phase < 4) begin
        count = forced_count[phase];
        trim = forced_trim[phase];
        write_reg(REG_SAMPLE_COUNT, count);
        write_reg(REG_TRIM_COUNT, {PAD_W'($urandom_range(0, 3)), trim});
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:69]:  count = SAMPLE_COUNT_W'($urandom_range(1, 8));
          [70:84]: count = SAMPLE_COUNT_W'($urandom_range(9, 31));
          [85:87]: count = 6'd0;
          default: count = SAMPLE_COUNT_W'($urandom_range(32, 63));
        endcase
        n = batch_size(count);
        if ($urandom_range(0, 99) < 75) trim = TRIM_COUNT_W'($urandom_range(0, (n - 1) / 2));
        else trim = TRIM_COUNT_W'($urandom_range(0, 15));
        // Mostly both registers, in either order; sometimes only one.
        case ($urandom_range(0, 9))
          0, 1: write_reg(REG_SAMPLE_COUNT, count);
          2: write_reg(REG_TRIM_COUNT, {PAD_W'($urandom_range(0, 3)), trim});
          3, 4, 5: begin
            write_reg(REG_TRIM_COUNT, {PAD_W'($urandom_range(0, 3)), trim});
            write_reg(REG_SAMPLE_COUNT, count);
          end
          default: begin
            write_reg(REG_SAMPLE_COUNT, count);
            write_reg(REG_TRIM_COUNT, {PAD_W'($urandom_range(0, 3)), trim});
          end
        endcase
      end
      n = batch_size(batch_reg);
      // Whole batches most of the time; otherwise a ragged run that may leave a part batch.
      if ($urandom_range(0, 9) < 6) len = n * ((n >= 24) ? 1 : $urandom_range(1, 3));
      else len = $urandom_range(1, 40);
      for (int k = 0; k < len && sent < RANDOM_WORDS; k++) begin
        steady = (sent >= 300 && sent < 500);
        push_sample(pick_sample(), 1'b0, '0, 1'b0);
        sent++;
      end
      phase++;
    end
    steady = 1'b0;

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_means.size() == 0) begin
      $display("trimmed_mean_filter: match");
    end else begin
      $display("trimmed_mean_filter: mismatch");
    end
    $finish;
  end

endmodule
